// ----- hw/rtl/i2crs_pkg.sv -----
// shared types and constants for the i2c register slave with sensor frame collector
package i2crs_pkg;

    localparam int REGISTER_COUNT_DEF = 256;
    localparam int FRAME_LENGTH       = 6;
    localparam int FRAME_COPY         = FRAME_LENGTH - 1;
    localparam int FPOS_W             = 3;

    localparam logic [2:0] CMD_START   = 3'd0;
    localparam logic [2:0] CMD_RECEIVE = 3'd1;
    localparam logic [2:0] CMD_SENT    = 3'd2;
    localparam logic [2:0] CMD_STOP    = 3'd3;
    localparam logic [2:0] CMD_FRAME   = 3'd4;

    localparam int REG_DISPLAY = 8;
    localparam int REG_SENSOR  = 9;
    localparam int REG_SLEEP   = 16;

    localparam logic [7:0] BYTE_NACK = 8'hFF;
    localparam logic [7:0] BYTE_ONE  = 8'h01;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic accept;
        logic finish;
    } ctl_cmd_t;

    typedef struct packed {
        logic need_read;
    } dp_sts_t;

endpackage

// ----- hw/rtl/i2crs_ctrl.sv -----
// handshake controller: accepts items and sequences the register file read
module i2crs_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  i2crs_pkg::dp_sts_t sts,
    output i2crs_pkg::ctl_cmd_t cmd
);
    import i2crs_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    // output register free, or emptied at this edge
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.accept     = 1'b0;
        cmd.finish     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.accept = 1'b1;
                    if (sts.need_read)
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.finish     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/i2crs_dp.sv -----
// datapath: register file, pointer, bus flags, frame store and result register
module i2crs_dp #(
    parameter int REGISTER_COUNT = i2crs_pkg::REGISTER_COUNT_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  i2crs_pkg::ctl_cmd_t cmd,
    output i2crs_pkg::dp_sts_t  sts,
    input  logic [2:0]          command,
    input  logic [7:0]          data_byte,
    input  logic                master_nack,
    output logic [7:0]          transmit_byte,
    output logic                display_power,
    output logic                sensor_power,
    output logic                sleep_request
);
    import i2crs_pkg::*;

    localparam int IDX_W = $clog2(REGISTER_COUNT);
    localparam logic [10:0] RC1 = 11'(REGISTER_COUNT);
    localparam logic [10:0] RC2 = 11'(2 * REGISTER_COUNT);
    localparam logic [10:0] RC4 = 11'(4 * REGISTER_COUNT);
    localparam logic [IDX_W-1:0] IDX_DISPLAY = IDX_W'(REG_DISPLAY);
    localparam logic [IDX_W-1:0] IDX_SENSOR  = IDX_W'(REG_SENSOR);
    localparam logic [IDX_W-1:0] IDX_SLEEP   = IDX_W'(REG_SLEEP);
    localparam logic [IDX_W-1:0] IDX_FIRST   = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(FRAME_COPY);

    // pointer modulo register count, quotient is at most seven
    function automatic logic [IDX_W-1:0] file_idx(input logic [7:0] p);
        logic [10:0] r;
        r = {3'b000, p};
        if (r >= RC4)
        begin
            r = r - RC4;
        end
        if (r >= RC2)
        begin
            r = r - RC2;
        end
        if (r >= RC1)
        begin
            r = r - RC1;
        end
        return r[IDX_W-1:0];
    endfunction

    logic [7:0] mem [REGISTER_COUNT];
    logic [REGISTER_COUNT-1:0] vld_reg;

    logic [7:0]        ptr_reg, ptr_next;
    logic              await_dev_reg, await_dev_next;
    logic              await_reg_reg, await_reg_next;
    logic [7:0]        hold_reg, hold_next;
    logic [FPOS_W-1:0] fpos_reg, fpos_next;
    logic              pend_reg, pend_next;
    logic              disp_reg, disp_next;
    logic              sens_reg, sens_next;
    logic              sleep_reg, sleep_next;
    logic [7:0]        low_reg [FRAME_COPY];
    logic [7:0]        low_next [FRAME_COPY];
    logic [7:0]        fs_reg [FRAME_COPY];
    logic [7:0]        fs_next [FRAME_COPY];

    logic [7:0]        mem_q_reg;
    logic              rd_vld_reg;
    logic              rd_low_sel_reg;
    logic [7:0]        rd_low_reg;
    logic              rd_def_reg;

    logic [7:0]        out_tx_reg;
    logic              out_disp_reg, out_sens_reg, out_sleep_reg;

    logic [IDX_W-1:0]  wr_idx, rd_idx;
    logic [FPOS_W-1:0] wr_low_k, rd_low_k;
    logic              wr_low_hit, rd_low_hit;
    logic              wr_mem;
    logic [FPOS_W-1:0] pos_eff, pos_inc;
    logic [7:0]        ptr_inc;
    logic              load_out;

    assign ptr_inc    = ptr_reg + 8'd1;
    assign wr_idx     = file_idx(ptr_reg);
    assign rd_idx     = file_idx((command == CMD_SENT) ? ptr_inc : data_byte);
    assign wr_low_hit = (wr_idx >= IDX_FIRST) && (wr_idx <= IDX_LAST);
    assign rd_low_hit = (rd_idx >= IDX_FIRST) && (rd_idx <= IDX_LAST);
    assign wr_low_k   = FPOS_W'(wr_idx - IDX_FIRST);
    assign rd_low_k   = FPOS_W'(rd_idx - IDX_FIRST);
    assign pos_eff    = (fpos_reg >= FPOS_W'(FRAME_LENGTH)) ? '0 : fpos_reg;
    assign pos_inc    = pos_eff + FPOS_W'(1);

    assign sts.need_read = ((command == CMD_RECEIVE) && !await_dev_reg && await_reg_reg)
                        || ((command == CMD_SENT) && !master_nack);

    assign load_out = (cmd.accept && !sts.need_read) || cmd.finish;

    always_comb
    begin
        ptr_next       = ptr_reg;
        await_dev_next = await_dev_reg;
        await_reg_next = await_reg_reg;
        hold_next      = hold_reg;
        fpos_next      = fpos_reg;
        pend_next      = pend_reg;
        disp_next      = disp_reg;
        sens_next      = sens_reg;
        sleep_next     = sleep_reg;
        low_next       = low_reg;
        fs_next        = fs_reg;
        wr_mem         = 1'b0;
        if (cmd.accept)
        begin
            case (command)
                CMD_RECEIVE:
                begin
                    if (await_dev_reg)
                    begin
                        await_dev_next = 1'b0;
                    end
                    else if (await_reg_reg)
                    begin
                        await_reg_next = 1'b0;
                        ptr_next       = data_byte;
                    end
                    else
                    begin
                        if (wr_low_hit)
                        begin
                            low_next[wr_low_k] = data_byte;
                        end
                        else
                        begin
                            wr_mem = 1'b1;
                        end
                        if (wr_idx == IDX_DISPLAY)
                        begin
                            disp_next = (data_byte == BYTE_ONE);
                        end
                        if (wr_idx == IDX_SENSOR)
                        begin
                            sens_next = (data_byte == BYTE_ONE);
                        end
                        if (wr_idx == IDX_SLEEP)
                        begin
                            sleep_next = (data_byte == BYTE_ONE);
                        end
                        ptr_next = ptr_inc;
                    end
                end
                CMD_SENT:
                begin
                    if (master_nack)
                    begin
                        hold_next = BYTE_NACK;
                    end
                    else
                    begin
                        ptr_next = ptr_inc;
                    end
                end
                CMD_STOP:
                begin
                    await_dev_next = 1'b1;
                    await_reg_next = 1'b1;
                end
                CMD_FRAME:
                begin
                    // byte 0 of a frame is never copied, so it is not kept
                    if (pos_eff != '0)
                    begin
                        fs_next[pos_eff - FPOS_W'(1)] = data_byte;
                    end
                    if (pos_inc >= FPOS_W'(FRAME_LENGTH))
                    begin
                        fpos_next = '0;
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        fpos_next = pos_inc;
                    end
                end
                default:
                begin
                end
            endcase
            // frame copy at end of step, after any register write
            if (pend_next && sens_next)
            begin
                low_next  = fs_next;
                pend_next = 1'b0;
            end
        end
        if (cmd.finish)
        begin
            if (rd_low_sel_reg)
            begin
                hold_next = rd_low_reg;
            end
            else if (rd_vld_reg)
            begin
                hold_next = mem_q_reg;
            end
            else
            begin
                hold_next = {7'd0, rd_def_reg};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            await_dev_reg <= 1'b1;
            await_reg_reg <= 1'b1;
            hold_reg      <= '0;
            fpos_reg      <= '0;
            pend_reg      <= 1'b0;
            disp_reg      <= 1'b1;
            sens_reg      <= 1'b0;
            sleep_reg     <= 1'b0;
            vld_reg       <= '0;
            out_tx_reg    <= '0;
            out_disp_reg  <= 1'b1;
            out_sens_reg  <= 1'b0;
            out_sleep_reg <= 1'b0;
            for (int k = 0; k < FRAME_COPY; k++)
            begin
                low_reg[k] <= '0;
            end
        end
        else
        begin
            ptr_reg       <= ptr_next;
            await_dev_reg <= await_dev_next;
            await_reg_reg <= await_reg_next;
            hold_reg      <= hold_next;
            fpos_reg      <= fpos_next;
            pend_reg      <= pend_next;
            disp_reg      <= disp_next;
            sens_reg      <= sens_next;
            sleep_reg     <= sleep_next;
            low_reg       <= low_next;
            if (wr_mem)
            begin
                vld_reg[wr_idx] <= 1'b1;
            end
            if (load_out)
            begin
                out_tx_reg    <= hold_next;
                out_disp_reg  <= disp_next;
                out_sens_reg  <= sens_next;
                out_sleep_reg <= sleep_next;
            end
        end
    end

    // register file memory, unwritten entries read through the valid bits
    always_ff @(posedge clk)
    begin
        if (wr_mem)
        begin
            mem[wr_idx] <= data_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mem_q_reg      <= mem[rd_idx];
            rd_vld_reg     <= vld_reg[rd_idx];
            rd_low_sel_reg <= rd_low_hit;
            rd_low_reg     <= low_reg[rd_low_k];
            rd_def_reg     <= (rd_idx == IDX_DISPLAY);
        end
        fs_reg <= fs_next;
    end

    assign transmit_byte = out_tx_reg;
    assign display_power = out_disp_reg;
    assign sensor_power  = out_sens_reg;
    assign sleep_request = out_sleep_reg;

endmodule

// ----- hw/rtl/i2c_register_slave_with_sensor_frame_top.sv -----
// a transfer loads the result register as it is taken; a register file read (register
// address byte, or byte sent with ack) goes through ST_LOAD and the memory port first
// throughput: one item per cycle while the result is taken, none taken during ST_LOAD
// reset: asynchronous active low; control state clears at once, the register file
// reads as its reset values through per-entry valid bits, no clearing pass
module i2c_register_slave_with_sensor_frame_top #(
    parameter int REGISTER_COUNT = i2crs_pkg::REGISTER_COUNT_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] command,
    input  logic [7:0] data_byte,
    input  logic       master_nack,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] transmit_byte,
    output logic       display_power,
    output logic       sensor_power,
    output logic       sleep_request
);
    import i2crs_pkg::*;

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    i2crs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    i2crs_dp #(
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .command       (command),
        .data_byte     (data_byte),
        .master_nack   (master_nack),
        .transmit_byte (transmit_byte),
        .display_power (display_power),
        .sensor_power  (sensor_power),
        .sleep_request (sleep_request)
    );

endmodule

// ----- hw/rtl/i2crs_chk.sv -----
// port-level checker for the register slave top level, with its bind
module i2crs_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [2:0] command,
    input logic       master_nack,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] transmit_byte
);
    import i2crs_pkg::*;

    logic in_xfer;
    assign in_xfer = in_valid && in_ready;

    // a waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(transmit_byte))
        else $error("result changed while stalled");

    // no new item while the result register is full and stalled
    a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken with result register blocked");

    // nack loads all ones in the next result
    a_nack_byte: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (command == CMD_SENT) && master_nack
        |=> out_valid && (transmit_byte == BYTE_NACK))
        else $error("nack did not load all ones");

    // start leaves the transmit byte alone
    a_start_keep: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (command == CMD_START)
        |=> out_valid && (transmit_byte == $past(transmit_byte)))
        else $error("start changed the transmit byte");

endmodule

bind i2c_register_slave_with_sensor_frame_top i2crs_chk u_i2crs_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .command       (command),
    .master_nack   (master_nack),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .transmit_byte (transmit_byte)
);

// ----- sim/i2c_register_slave_with_sensor_frame_top_tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the i2c register slave with sensor frame collector
module i2c_register_slave_with_sensor_frame_top_tb;
    import i2crs_pkg::*;

    localparam int REG_COUNT = REGISTER_COUNT_DEF;
    localparam int DIR_ROWS = 26;
    localparam int RANDOM_ITEMS = 1525;
    localparam int HOLD_CYCLES = 300;
    localparam int HOLD_AFTER = 400;

    // command codes the block ignores
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    typedef struct packed {
        logic [7:0] tx;
        logic       disp;
        logic       sens;
        logic       sleep;
    } bus_status_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  data;
        logic        nack;
        logic        typed;
        bus_status_t status;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [2:0] command = CMD_START;
    logic [7:0] data_byte = 8'h00;
    logic       master_nack = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] transmit_byte;
    logic       display_power;
    logic       sensor_power;
    logic       sleep_request;

    // predicted slave state
    logic [7:0] reg_image [REG_COUNT];
    logic [7:0] ptr;
    logic       want_dev;
    logic       want_reg;
    logic [7:0] tx_hold;
    logic [2:0] frm_pos;
    logic [7:0] frm_bytes [FRAME_LENGTH];
    logic       frm_ready;

    bus_status_t pending_status [$];
    int errors = 0;
    int accepted_items = 0;
    int effective_items = 0;
    int writes_seen = 0;
    int reads_seen = 0;
    int frames_copied = 0;
    int results_seen = 0;
    bit stimulus_done = 0;

    stim_row_t directed_rows [DIR_ROWS] = '{
        '{CMD_START,   8'h00, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
        '{CMD_RECEIVE, 8'hA0, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b0, 1'b0}},
        '{CMD_RECEIVE, 8'h08, 1'b0, 1'b1, '{8'h01, 1'b1, 1'b0, 1'b0}},
        '{CMD_SENT,    8'h00, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
        '{CMD_STOP,    8'h00, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0, 1'b0}},
        '{CMD_RECEIVE, 8'h00, 1'b1, 1'b0, '0},
        '{CMD_RECEIVE, 8'h09, 1'b0, 1'b0, '0},
        '{CMD_RECEIVE, 8'h01, 1'b0, 1'b0, '0},
        '{CMD_FRAME,   8'h00, 1'b0, 1'b0, '0},
        '{CMD_FRAME,   8'hFF, 1'b1, 1'b0, '0},
        '{CMD_FRAME,   8'h80, 1'b0, 1'b0, '0},
        '{CMD_FRAME,   8'h55, 1'b0, 1'b0, '0},
        '{CMD_FRAME,   8'hAA, 1'b0, 1'b0, '0},
        '{CMD_FRAME,   8'h01, 1'b0, 1'b0, '0},
        '{CMD_RSVD5,   8'hFF, 1'b1, 1'b0, '0},
        '{CMD_RSVD7,   8'h5A, 1'b1, 1'b0, '0},
        '{CMD_STOP,    8'h00, 1'b0, 1'b0, '0},
        '{CMD_RECEIVE, 8'hFF, 1'b0, 1'b0, '0},
        '{CMD_RECEIVE, 8'hFF, 1'b0, 1'b0, '0},
        '{CMD_RECEIVE, 8'h01, 1'b0, 1'b0, '0},
        '{CMD_SENT,    8'h00, 1'b0, 1'b0, '0},
        '{CMD_SENT,    8'h00, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b0}},
        '{CMD_STOP,    8'h00, 1'b0, 1'b0, '0},
        '{CMD_RECEIVE, 8'h00, 1'b0, 1'b0, '0},
        '{CMD_RECEIVE, 8'h10, 1'b0, 1'b0, '0},
        '{CMD_RECEIVE, 8'h01, 1'b0, 1'b0, '0}
    };

    i2c_register_slave_with_sensor_frame_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .data_byte     (data_byte),
        .master_nack   (master_nack),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .transmit_byte (transmit_byte),
        .display_power (display_power),
        .sensor_power  (sensor_power),
        .sleep_request (sleep_request)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("i2c_register_slave_with_sensor_frame_top regression: fail");
        $finish;
    end

    // stretches with no idling on either side
    function automatic bit calm_phase();
        return ((accepted_items / 150) % 4) == 2;
    endfunction

    // applies one bus or frame event to the predicted state, returns the outputs
    function automatic bus_status_t advance_slave(input logic [2:0] cmd,
                                                  input logic [7:0] data,
                                                  input logic nack);
        bus_status_t st;
        int k;
        case (cmd)
            CMD_RECEIVE:
            begin
                if (want_dev)
                    want_dev = 1'b0;
                else if (want_reg)
                begin
                    want_reg = 1'b0;
                    ptr = data;
                    tx_hold = reg_image[ptr % REG_COUNT];
                end
                else
                begin
                    reg_image[ptr % REG_COUNT] = data;
                    ptr = ptr + 8'd1;
                    writes_seen++;
                end
            end
            CMD_SENT:
            begin
                if (nack)
                    tx_hold = BYTE_NACK;
                else
                begin
                    ptr = ptr + 8'd1;
                    tx_hold = reg_image[ptr % REG_COUNT];
                    reads_seen++;
                end
            end
            CMD_STOP:
            begin
                want_dev = 1'b1;
                want_reg = 1'b1;
            end
            CMD_FRAME:
            begin
                if (frm_pos >= FRAME_LENGTH)
                    frm_pos = '0;
                frm_bytes[frm_pos] = data;
                frm_pos = frm_pos + 3'd1;
                if (frm_pos >= FRAME_LENGTH)
                begin
                    frm_pos = '0;
                    frm_ready = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        // a complete frame lands once the sensor is powered
        if (frm_ready && reg_image[REG_SENSOR] == BYTE_ONE)
        begin
            for (k = 1; k <= FRAME_COPY; k++)
                reg_image[k] = frm_bytes[k];
            frm_ready = 1'b0;
            frames_copied++;
        end
        st.tx = tx_hold;
        st.disp = reg_image[REG_DISPLAY] == BYTE_ONE;
        st.sens = reg_image[REG_SENSOR] == BYTE_ONE;
        st.sleep = reg_image[REG_SLEEP] == BYTE_ONE;
        return st;
    endfunction

    task automatic offer(input stim_row_t row);
        int gap;
        int r;
        bus_status_t predicted;
        r = $urandom_range(0, 99);
        if (calm_phase() || r < 60)
            gap = 0;
        else if (r < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(8, 30);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= row.cmd;
        data_byte <= row.data;
        master_nack <= row.nack;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = advance_slave(row.cmd, row.data, row.nack);
        pending_status.push_back(row.typed ? row.status : predicted);
        accepted_items++;
        if (row.cmd != CMD_START && row.cmd <= CMD_FRAME)
            effective_items++;
    endtask

    task automatic bus_event(input logic [2:0] cmd, input logic [7:0] data, input logic nack);
        stim_row_t row;
        row = '0;
        row.cmd = cmd;
        row.data = data;
        row.nack = nack;
        offer(row);
    endtask

    // register address: mostly low registers, often the control ones, some near the wrap
    function automatic logic [7:0] pick_reg();
        int r;
        r = $urandom_range(0, 11);
        if (r == 0)
            return 8'(REG_SENSOR);
        else if (r == 1)
            return $urandom_range(0, 1) ? 8'(REG_DISPLAY) : 8'(REG_SLEEP);
        else if (r < 8)
            return 8'($urandom_range(0, 20));
        else if (r < 9)
            return 8'($urandom_range(248, 255));
        return 8'($urandom_range(0, 255));
    endfunction

    // control registers only react to exactly one, so favor zero and one
    function automatic logic [7:0] pick_value();
        if ($urandom_range(0, 2) == 0)
            return 8'($urandom_range(0, 1));
        return 8'($urandom_range(0, 255));
    endfunction

    initial
    begin
        int i;
        int kind;
        int n;
        for (i = 0; i < REG_COUNT; i++)
            reg_image[i] = 8'h00;
        reg_image[REG_DISPLAY] = BYTE_ONE;
        ptr = 8'h00;
        want_dev = 1'b1;
        want_reg = 1'b1;
        tx_hold = 8'h00;
        frm_pos = '0;
        frm_ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
            offer(directed_rows[i]);

        while (effective_items < DIR_ROWS + RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 70)
            begin
                // register write or read transaction, sometimes without the stop
                if ($urandom_range(0, 9) != 0)
                    bus_event(CMD_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                if ($urandom_range(0, 3) == 0)
                    bus_event(CMD_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                bus_event(CMD_RECEIVE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                bus_event(CMD_RECEIVE, pick_reg(), 1'($urandom_range(0, 1)));
                n = $urandom_range(1, 6);
                if (kind < 45)
                begin
                    repeat (n)
                        bus_event(CMD_RECEIVE, pick_value(), 1'($urandom_range(0, 1)));
                end
                else
                begin
                    repeat (n)
                        bus_event(CMD_SENT, 8'($urandom_range(0, 255)),
                                  $urandom_range(0, 5) == 0);
                end
            end
            else if (kind < 88)
            begin
                // sensor frame, now and then cut short
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 5) : FRAME_LENGTH;
                repeat (n)
                    bus_event(CMD_FRAME, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            end
            else
                bus_event(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
        end
        in_valid <= 1'b0;
        stimulus_done = 1;

        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("run covered %0d transfers in, %0d results out: %0d register writes,",
                 accepted_items, results_seen, writes_seen);
        $display("%0d acked reads and %0d sensor frames copied into the register file",
                 reads_seen, frames_copied);
        if (errors == 0 && pending_status.size() == 0)
            $display("i2c_register_slave_with_sensor_frame_top regression: pass");
        else
            $display("i2c_register_slave_with_sensor_frame_top regression: fail");
        $finish;
    end

    // result side: compare each transfer, then decide the next ready
    initial
    begin
        bus_status_t want;
        int stall_left;
        int r;
        bit hold_done;
        stall_left = 0;
        hold_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_status.size() == 0)
                begin
                    $error("unexpected result: transmit_byte %h", transmit_byte);
                    errors++;
                end
                else
                begin
                    want = pending_status.pop_front();
                    if (transmit_byte !== want.tx)
                    begin
                        $error("transmit_byte: expected %h, got %h", want.tx, transmit_byte);
                        errors++;
                    end
                    if (display_power !== want.disp)
                    begin
                        $error("display_power: expected %b, got %b", want.disp, display_power);
                        errors++;
                    end
                    if (sensor_power !== want.sens)
                    begin
                        $error("sensor_power: expected %b, got %b", want.sens, sensor_power);
                        errors++;
                    end
                    if (sleep_request !== want.sleep)
                    begin
                        $error("sleep_request: expected %b, got %b", want.sleep, sleep_request);
                        errors++;
                    end
                end
            end
            // one long hold-off so the block backs up into its input
            if (!hold_done && accepted_items >= HOLD_AFTER)
            begin
                hold_done = 1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left == 0 && !calm_phase() && !stimulus_done)
            begin
                r = $urandom_range(0, 99);
                if (r < 20)
                    stall_left = $urandom_range(1, 3);
                else if (r < 23)
                    stall_left = $urandom_range(10, 40);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

endmodule
